// File: rtl/qph_pkg.sv
// Shared constants for the quadratic-probe hash table: codes, FNV-1 constants,
// register indexes and reset values. No dependencies.
package qph_pkg;

  localparam int DEFAULT_DEPTH = 16;

  localparam logic [63:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
  // FNV 64-bit prime is 2^40 + 0x1B3
  localparam int          FNV_HI_SHIFT = 40;
  localparam logic [8:0]  FNV_LO       = 9'h1B3;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_NO_SLOT = 2'd2;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_MAX_LIVE = 2'd1;

  localparam logic [4:0] CAPACITY_RST = 5'd11;
  localparam logic [4:0] MAX_LIVE_RST = 5'd5;

endpackage

// File: rtl/qph_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module qph_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/qph_front.sv
// Front end: takes request beats, runs FNV-1 over the key (one byte a cycle)
// and reduces the hash modulo the capacity (four bits a cycle). Uses qph_pkg.
module qph_front import qph_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH,
  parameter int SW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1,
  parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          busy,
  input  logic [CW-1:0] ceff,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_action,
  input  logic [63:0]   in_key,
  input  logic [63:0]   in_value_in,
  output logic          q_valid,
  input  logic          q_ready,
  output logic [1:0]    q_action,
  output logic [63:0]   q_key,
  output logic [63:0]   q_value,
  output logic [SW-1:0] q_home
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HASH = 2'd1;
  localparam logic [1:0] F_MOD  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [63:0]   hash_r, hash_nxt;
  logic [63:0]   kshift_r, kshift_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [1:0]    act_r;
  logic [63:0]   key_r, val_r;

  logic [63:0]   mul_step;
  logic [63:0]   mod_h;
  logic [CW-1:0] mod_rem;
  logic [CW:0]   mod_t;

  assign in_ready = (state_r == F_IDLE) && !busy;
  assign q_valid  = (state_r == F_PUSH);
  assign q_action = act_r;
  assign q_key    = key_r;
  assign q_value  = val_r;
  assign q_home   = rem_r[SW-1:0];

  assign mul_step = (hash_r << FNV_HI_SHIFT) + (hash_r * 64'(FNV_LO));

  // four restoring steps of hash mod capacity
  always_comb begin
    mod_h   = hash_r;
    mod_rem = rem_r;
    mod_t   = '0;
    for (int k = 0; k < 4; k++) begin
      mod_t = {mod_rem, mod_h[63]};
      mod_h = mod_h << 1;
      if (mod_t >= (CW+1)'(ceff)) begin
        mod_t = mod_t - (CW+1)'(ceff);
      end
      mod_rem = mod_t[CW-1:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    hash_nxt   = hash_r;
    kshift_nxt = kshift_r;
    rem_nxt    = rem_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid && in_ready) begin
          hash_nxt   = FNV_BASIS;
          kshift_nxt = in_key;
          cnt_nxt    = '0;
          state_nxt  = F_HASH;
        end
      end
      F_HASH: begin
        hash_nxt   = mul_step ^ {56'd0, kshift_r[7:0]};
        kshift_nxt = kshift_r >> 8;
        cnt_nxt    = cnt_r + 4'd1;
        if (cnt_r == 4'd7) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = F_MOD;
        end
      end
      F_MOD: begin
        hash_nxt = mod_h;
        rem_nxt  = mod_rem;
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (q_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r    <= cnt_nxt;
    hash_r   <= hash_nxt;
    kshift_r <= kshift_nxt;
    rem_r    <= rem_nxt;
    if (in_valid && in_ready) begin
      act_r <= in_action;
      key_r <= in_key;
      val_r <= in_value_in;
    end
  end

endmodule

// File: rtl/qph_queue.sv
// Two-entry FIFO between the hashing front end and the probing back end.
// No dependencies.
module qph_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] ent_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/qph_back.sv
// Back end: clears the slot marks after reset, then probes the table for each
// queued non-NOP request, updates the slot RAMs and counters, holds the result.
// Uses qph_pkg and qph_ram.
module qph_back import qph_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH,
  parameter int SW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1,
  parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [CW-1:0] ceff,
  input  logic [4:0]    max_live,
  output logic          busy,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [1:0]    q_action,
  input  logic [63:0]   q_key,
  input  logic [63:0]   q_value,
  input  logic [SW-1:0] q_home,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_found,
  output logic [63:0]   out_value_out,
  output logic [1:0]    out_status,
  output logic [4:0]    out_live_count,
  output logic [31:0]   out_probe_total
);

  localparam logic [2:0] B_CLEAR = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_ADDR  = 3'd2;
  localparam logic [2:0] B_CHECK = 3'd3;
  localparam logic [2:0] B_DONE  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [SW-1:0] clr_r, clr_nxt;
  logic [1:0]    act_r;
  logic [63:0]   key_r, val_r;
  logic [SW-1:0] slot_r, slot_nxt, inc_r, inc_nxt, i_r, i_nxt, lim_r, lim_nxt;
  logic          free_ok_r, free_ok_nxt, hit_r, hit_nxt;
  logic [SW-1:0] free_slot_r, free_slot_nxt, free_i_r, free_i_nxt, hit_slot_r, hit_slot_nxt;
  logic [63:0]   hit_val_r, hit_val_nxt;
  logic [4:0]    live_r, live_nxt;
  logic [31:0]   probe_r, probe_nxt;
  logic          out_valid_r;
  logic          found_r;
  logic [63:0]   vout_r;
  logic [1:0]    status_r;

  logic [1:0]    mark_rd;
  logic [63:0]   key_rd, val_rd;
  logic          mark_we, key_we, val_we;
  logic [SW-1:0] mark_wa, kv_wa;
  logic [1:0]    mark_wd;

  logic [CW:0]   slot_sum, inc_sum;
  logic [SW-1:0] slot_adv, inc_adv;
  logic [32:0]   probe_sum;
  logic          out_free, finish;
  logic          res_found;
  logic [63:0]   res_vout;
  logic [1:0]    res_status;

  qph_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_marks (
    .clk(clk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
    .raddr(slot_r), .rdata(mark_rd)
  );
  qph_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_keys (
    .clk(clk), .we(key_we), .waddr(kv_wa), .wdata(key_r),
    .raddr(slot_r), .rdata(key_rd)
  );
  qph_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_vals (
    .clk(clk), .we(val_we), .waddr(kv_wa), .wdata(val_r),
    .raddr(slot_r), .rdata(val_rd)
  );

  assign busy            = (state_r == B_CLEAR);
  assign q_ready         = (state_r == B_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_value_out   = vout_r;
  assign out_status      = status_r;
  assign out_live_count  = live_r;
  assign out_probe_total = probe_r;

  // next quadratic offset: slot += 2i+1, both kept mod capacity
  assign slot_sum  = (CW+1)'(slot_r) + (CW+1)'(inc_r);
  assign inc_sum   = (CW+1)'(inc_r) + (CW+1)'(2);
  assign slot_adv  = (slot_sum >= (CW+1)'(ceff)) ? SW'(slot_sum - (CW+1)'(ceff))
                                                 : SW'(slot_sum);
  assign inc_adv   = (inc_sum >= (CW+1)'(ceff)) ? SW'(inc_sum - (CW+1)'(ceff))
                                                : SW'(inc_sum);
  assign probe_sum = {1'b0, probe_r} + 33'(free_i_r);
  assign out_free  = !out_valid_r || out_ready;
  assign finish    = (state_r == B_DONE) && out_free;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    slot_nxt      = slot_r;
    inc_nxt       = inc_r;
    i_nxt         = i_r;
    lim_nxt       = lim_r;
    free_ok_nxt   = free_ok_r;
    free_slot_nxt = free_slot_r;
    free_i_nxt    = free_i_r;
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    hit_val_nxt   = hit_val_r;
    live_nxt      = live_r;
    probe_nxt     = probe_r;
    mark_we       = 1'b0;
    mark_wa       = clr_r;
    mark_wd       = MARK_EMPTY;
    key_we        = 1'b0;
    val_we        = 1'b0;
    kv_wa         = hit_slot_r;
    res_found     = 1'b0;
    res_vout      = '0;
    res_status    = ST_DONE;
    case (state_r)
      B_CLEAR: begin
        mark_we = 1'b1;
        clr_nxt = clr_r + SW'(1);
        if (clr_r == SW'(TABLE_DEPTH - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid) begin
          slot_nxt    = q_home;
          inc_nxt     = SW'(1);
          i_nxt       = '0;
          lim_nxt     = SW'(ceff >> 1);
          free_ok_nxt = 1'b0;
          hit_nxt     = 1'b0;
          state_nxt   = (q_action == ACT_NOP) ? B_DONE : B_ADDR;
        end
      end
      B_ADDR: state_nxt = B_CHECK;
      B_CHECK: begin
        if (mark_rd != MARK_LIVE && !free_ok_r) begin
          free_ok_nxt   = 1'b1;
          free_slot_nxt = slot_r;
          free_i_nxt    = i_r;
        end
        if (mark_rd == MARK_LIVE && key_rd == key_r) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = slot_r;
          hit_val_nxt  = val_rd;
          state_nxt    = B_DONE;
        end else if (mark_rd == MARK_EMPTY || i_r == lim_r) begin
          state_nxt = B_DONE;
        end else begin
          i_nxt     = i_r + SW'(1);
          slot_nxt  = slot_adv;
          inc_nxt   = inc_adv;
          state_nxt = B_ADDR;
        end
      end
      B_DONE: begin
        res_found = hit_r;
        case (act_r)
          ACT_INSERT: begin
            if (!hit_r) begin
              if (6'(live_r) + 6'd1 > 6'(max_live)) begin
                res_status = ST_REFUSED;
              end else if (!free_ok_r) begin
                res_status = ST_NO_SLOT;
              end
            end
          end
          ACT_LOOKUP, ACT_DELETE: res_vout = hit_r ? hit_val_r : 64'd0;
          default: res_found = 1'b0;
        endcase
        if (finish) begin
          state_nxt = B_IDLE;
          if (act_r == ACT_INSERT && hit_r) begin
            val_we = 1'b1;
          end else if (act_r == ACT_INSERT && res_status == ST_DONE) begin
            kv_wa     = free_slot_r;
            mark_wa   = free_slot_r;
            mark_wd   = MARK_LIVE;
            mark_we   = 1'b1;
            key_we    = 1'b1;
            val_we    = 1'b1;
            live_nxt  = live_r + 5'd1;
            probe_nxt = probe_sum[32] ? 32'hFFFF_FFFF : probe_sum[31:0];
          end else if (act_r == ACT_DELETE && hit_r) begin
            mark_wa = hit_slot_r;
            mark_wd = MARK_TOMB;
            mark_we = 1'b1;
            if (live_r != 5'd0) live_nxt = live_r - 5'd1;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      live_r      <= '0;
      probe_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      live_r  <= live_nxt;
      probe_r <= probe_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    slot_r      <= slot_nxt;
    inc_r       <= inc_nxt;
    i_r         <= i_nxt;
    lim_r       <= lim_nxt;
    free_ok_r   <= free_ok_nxt;
    free_slot_r <= free_slot_nxt;
    free_i_r    <= free_i_nxt;
    hit_r       <= hit_nxt;
    hit_slot_r  <= hit_slot_nxt;
    hit_val_r   <= hit_val_nxt;
    if (q_valid && q_ready) begin
      act_r <= q_action;
      key_r <= q_key;
      val_r <= q_value;
    end
    if (finish) begin
      found_r  <= res_found;
      vout_r   <= res_vout;
      status_r <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_check_after_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CHECK) |-> ($past(state_r) == B_ADDR))
    else $error("probe check without address cycle");
  a_probe_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ADDR || state_r == B_CHECK) |-> (i_r <= lim_r))
    else $error("probe index past window");
  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ADDR) |-> ((CW+1)'(slot_r) < (CW+1)'(ceff)))
    else $error("probe slot beyond capacity");
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == B_DONE))
    else $error("result raised outside completion");
`endif

endmodule

// File: rtl/quadratic_probe_hash_table_core.sv
// Top level of the quadratic-probe hash table: config registers, front end,
// request queue and back end. Uses qph_pkg, qph_front, qph_queue, qph_back.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    in_action, in_key, in_value_in
//  out_     output     out_valid/out_ready  out_found, out_value_out, out_status,
//                                           out_live_count, out_probe_total
//  cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Front: FNV-1 over the key, then the modulo; it takes a new request once the
// last is pushed. Back: a probe is an address and a check state (registered RAM
// read), up to capacity/2+1 probes, plus idle and done states; the slower of the
// two sets the rate. After reset the back end clears all TABLE_DEPTH marks;
// in_ready stays low meanwhile. A two-beat queue lets the front keep hashing
// while the back end probes or waits on out_ready. cfg_ready is always high.
module quadratic_probe_hash_table_core import qph_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [63:0] in_key,
  input  logic [63:0] in_value_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [63:0] out_value_out,
  output logic [1:0]  out_status,
  output logic [4:0]  out_live_count,
  output logic [31:0] out_probe_total
);

  localparam int SW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (CW > 5) ? CW : 5;
  localparam int QW = 2 + 64 + 64 + SW;

  logic [4:0]    capacity_r, max_live_r;
  logic [XW-1:0] cap_ext;
  logic [CW-1:0] ceff;
  logic          busy;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [1:0]    f_action, b_action;
  logic [63:0]   f_key, f_value, b_key, b_value;
  logic [SW-1:0] f_home, b_home;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RST;
      max_live_r <= MAX_LIVE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CAPACITY: capacity_r <= cfg_data;
        REG_MAX_LIVE: max_live_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // capacity clamped to [2, TABLE_DEPTH]
  assign cap_ext = XW'(capacity_r);
  assign ceff = (cap_ext < XW'(2))           ? CW'(2) :
                (cap_ext > XW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cap_ext);

  qph_front #(.TABLE_DEPTH(TABLE_DEPTH), .SW(SW), .CW(CW)) u_front (
    .clk(clk), .rst_n(rst_n), .busy(busy), .ceff(ceff),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_key(in_key), .in_value_in(in_value_in),
    .q_valid(f_valid), .q_ready(f_ready), .q_action(f_action),
    .q_key(f_key), .q_value(f_value), .q_home(f_home)
  );

  qph_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready),
    .push_data({f_action, f_key, f_value, f_home}),
    .pop_valid(b_valid), .pop_ready(b_ready),
    .pop_data({b_action, b_key, b_value, b_home})
  );

  qph_back #(.TABLE_DEPTH(TABLE_DEPTH), .SW(SW), .CW(CW)) u_back (
    .clk(clk), .rst_n(rst_n), .ceff(ceff), .max_live(max_live_r), .busy(busy),
    .q_valid(b_valid), .q_ready(b_ready), .q_action(b_action),
    .q_key(b_key), .q_value(b_value), .q_home(b_home),
    .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
    .out_value_out(out_value_out), .out_status(out_status),
    .out_live_count(out_live_count), .out_probe_total(out_probe_total)
  );

endmodule
